@@ src/zdss_pkg.sv @@
`default_nettype none

package zdss_pkg;

	localparam int unsigned MASK_W   = 16;
	localparam int unsigned THR_W    = 16;
	localparam int unsigned TYPES_W  = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned INDEX_W  = 2;

	typedef enum logic [1:0] {
		ZONE_OTHER     = 2'd0,
		ZONE_CLEAR     = 2'd1,
		ZONE_WARNING   = 2'd2,
		ZONE_FORBIDDEN = 2'd3
	} zone_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SAFE         = 3'd0,
		ST_WARNING      = 3'd1,
		ST_ALARM        = 3'd2,
		ST_PRE_BLOCKED  = 3'd3,
		ST_PRE_CHECKING = 3'd4
	} sys_status_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_ENTER_THR = 2'd0,
		REG_EXIT_THR  = 2'd1,
		REG_TYPES     = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic stable;
		logic quiet;
	} zone_flags_t;

	typedef struct packed {
		logic        alarm;
		logic        warning;
		sys_status_t status;
		logic        start;
	} frame_result_t;

endpackage

`default_nettype wire

@@ src/zone_debounce_safety_state.sv @@
// Debounced per-zone safety state, one frame per transaction.
//
// Input channel (in_valid/in_ready) carries one frame: zone_hit_mask and
// prestart. Output channel (out_valid/out_ready) returns exactly one result
// per frame: alarm_flag, warning_flag, system_status, start_allowed and
// stable_mask, in frame order.
// The frame is captured in an input register, then the zone counters,
// debounce flags and status priority are evaluated in one pass and land in
// the result register, which drives out_valid.
// Throughput is one frame per cycle while the receiver takes results; it
// is set by the single pass through the per-zone saturating counters,
// which all update in parallel.
// When the receiver stalls, the result register holds and the input
// register still takes one more frame; in_ready drops only while both are
// full, and rises again in the cycle the result is taken.
// Reset clears all run counters and stable flags, empties both registers and
// loads the thresholds with 3 and all zone types with other.
// cfg_en writes cfg_data to register cfg_index at once; write only when idle.
`default_nettype none

module zone_debounce_safety_state #(
	parameter int unsigned NUM_ZONES  = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_en,
	input  wire logic [zdss_pkg::INDEX_W-1:0]  cfg_index,
	input  wire logic [zdss_pkg::TYPES_W-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [zdss_pkg::MASK_W-1:0]   zone_hit_mask,
	input  wire logic                          prestart,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               alarm_flag,
	output logic                               warning_flag,
	output logic [zdss_pkg::STATUS_W-1:0]      system_status,
	output logic                               start_allowed,
	output logic [zdss_pkg::MASK_W-1:0]        stable_mask
);

	logic [zdss_pkg::THR_W-1:0]   enter_thr_q;
	logic [zdss_pkg::THR_W-1:0]   exit_thr_q;
	logic [zdss_pkg::TYPES_W-1:0] types_q;

	logic                         valid_s1;
	logic [zdss_pkg::MASK_W-1:0]  hits_s1;
	logic                         prestart_s1;

	logic                         valid_s2;
	zdss_pkg::frame_result_t      result_s2;
	logic [zdss_pkg::MASK_W-1:0]  stable_s2;

	logic                         adv;
	logic [NUM_ZONES-1:0]         stable;
	logic [NUM_ZONES-1:0]         quiet;
	logic [zdss_pkg::MASK_W-1:0]  stable_full;
	zdss_pkg::frame_result_t      result;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_thr_q <= zdss_pkg::THR_W'(3);
			exit_thr_q  <= zdss_pkg::THR_W'(3);
			types_q     <= '0;
		end else if (cfg_en) begin
			case (zdss_pkg::reg_index_t'(cfg_index))
				zdss_pkg::REG_ENTER_THR: enter_thr_q <= cfg_data[zdss_pkg::THR_W-1:0];
				zdss_pkg::REG_EXIT_THR:  exit_thr_q  <= cfg_data[zdss_pkg::THR_W-1:0];
				zdss_pkg::REG_TYPES:     types_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hits_s1     <= zone_hit_mask;
			prestart_s1 <= prestart;
		end
	end

	for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
		zdss_pkg::zone_flags_t flags;

		zdss_zone #(
			.COUNT_BITS(COUNT_BITS)
		) u_zone (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.hit      (hits_s1[z]),
			.enter_thr(enter_thr_q),
			.exit_thr (exit_thr_q),
			.flags    (flags)
		);

		assign stable[z] = flags.stable;
		assign quiet[z]  = flags.quiet;
	end

	zdss_status #(
		.NUM_ZONES(NUM_ZONES)
	) u_status (
		.stable    (stable),
		.quiet     (quiet),
		.type_codes(types_q),
		.prestart  (prestart_s1),
		.result    (result)
	);

	always_comb begin
		stable_full = '0;
		for (int z = 0; z < NUM_ZONES; z++) begin
			stable_full[z] = stable[z];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result;
			stable_s2 <= stable_full;
		end
	end

	assign out_valid     = valid_s2;
	assign alarm_flag    = result_s2.alarm;
	assign warning_flag  = result_s2.warning;
	assign system_status = result_s2.status;
	assign start_allowed = result_s2.start;
	assign stable_mask   = stable_s2;

endmodule

`default_nettype wire

@@ src/zdss_zone.sv @@
`default_nettype none

module zdss_zone #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       hit,
	input  wire logic [zdss_pkg::THR_W-1:0] enter_thr,
	input  wire logic [zdss_pkg::THR_W-1:0] exit_thr,
	output zdss_pkg::zone_flags_t           flags
);

	localparam int unsigned CMP_W = (COUNT_BITS > zdss_pkg::THR_W) ? COUNT_BITS : zdss_pkg::THR_W;

	logic [COUNT_BITS-1:0] enter_run_q;
	logic [COUNT_BITS-1:0] exit_run_q;
	logic                  stable_q;
	logic [COUNT_BITS-1:0] enter_nxt;
	logic [COUNT_BITS-1:0] exit_nxt;
	logic                  stable_nxt;

	always_comb begin
		enter_nxt  = '0;
		exit_nxt   = '0;
		stable_nxt = stable_q;
		if (hit) begin
			enter_nxt = (&enter_run_q) ? enter_run_q : enter_run_q + 1'b1;
			if (CMP_W'(enter_nxt) >= CMP_W'(enter_thr)) begin
				stable_nxt = 1'b1;
			end
		end else begin
			exit_nxt = (&exit_run_q) ? exit_run_q : exit_run_q + 1'b1;
			if (CMP_W'(exit_nxt) >= CMP_W'(exit_thr)) begin
				stable_nxt = 1'b0;
			end
		end
		flags.stable = stable_nxt;
		flags.quiet  = !stable_nxt && (CMP_W'(exit_nxt) >= CMP_W'(exit_thr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_run_q <= '0;
			exit_run_q  <= '0;
			stable_q    <= 1'b0;
		end else if (adv) begin
			enter_run_q <= enter_nxt;
			exit_run_q  <= exit_nxt;
			stable_q    <= stable_nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/zdss_status.sv @@
`default_nettype none

module zdss_status #(
	parameter int unsigned NUM_ZONES = 16
) (
	input  wire logic [NUM_ZONES-1:0]         stable,
	input  wire logic [NUM_ZONES-1:0]         quiet,
	input  wire logic [zdss_pkg::TYPES_W-1:0] type_codes,
	input  wire logic                         prestart,
	output zdss_pkg::frame_result_t           result
);

	logic               alarm;
	logic               warn;
	logic               clear_occupied;
	logic               has_clear;
	logic               clear_block;
	logic               clear_ok;
	zdss_pkg::zone_kind_t kind;

	always_comb begin
		alarm          = 1'b0;
		warn           = 1'b0;
		clear_occupied = 1'b0;
		has_clear      = 1'b0;
		clear_block    = 1'b0;
		kind           = zdss_pkg::ZONE_OTHER;
		for (int z = 0; z < NUM_ZONES; z++) begin
			kind = zdss_pkg::zone_kind_t'(type_codes[2*z +: 2]);
			case (kind)
				zdss_pkg::ZONE_CLEAR: begin
					has_clear      = 1'b1;
					clear_occupied = clear_occupied | stable[z];
					clear_block    = clear_block | !quiet[z];
				end
				zdss_pkg::ZONE_WARNING:   warn  = warn | stable[z];
				zdss_pkg::ZONE_FORBIDDEN: alarm = alarm | stable[z];
				default: ;
			endcase
		end
		clear_ok = has_clear && !clear_block;

		result.alarm   = alarm;
		result.warning = warn;
		result.start   = prestart && clear_ok && !warn && !alarm;
		if (alarm) begin
			result.status = zdss_pkg::ST_ALARM;
		end else if (prestart && clear_occupied) begin
			result.status = zdss_pkg::ST_PRE_BLOCKED;
		end else if (warn) begin
			result.status = zdss_pkg::ST_WARNING;
		end else if (prestart && !clear_ok) begin
			result.status = zdss_pkg::ST_PRE_CHECKING;
		end else begin
			result.status = zdss_pkg::ST_SAFE;
		end
	end

endmodule

`default_nettype wire
